### rtl/sfvr_pkg.sv
package sfvr_pkg;

    typedef enum logic [1:0] {
        OP_TO_SEED   = 2'd0,
        OP_FROM_SEED = 2'd1,
        OP_FROM_SWAP = 2'd2,
        OP_LERP      = 2'd3
    } t_op;

    localparam int VAL_W     = 26;
    localparam int MAX_STEPS = 24;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [16:0]      t_coef;
    typedef logic signed [42:0]      t_prod;
    typedef logic signed [43:0]      t_sum;
    typedef logic signed [33:0]      t_ang;
    typedef logic signed [41:0]      t_gprod;
    typedef logic signed [15:0]      t_word;

    localparam logic [7:0] CFG_COS_ALPHA = 8'd0;
    localparam logic [7:0] CFG_SIN_ALPHA = 8'd1;
    localparam logic [7:0] CFG_COS_BETA  = 8'd2;
    localparam logic [7:0] CFG_SIN_BETA  = 8'd3;

    localparam t_ang  ANG_QUARTER = 34'sd1073741824;
    localparam t_ang  ANG_TURN    = 34'sd4294967296;
    localparam t_word INV_GAIN    = 16'sd9949;
    localparam t_sum  RND_HALF    = 44'sd8192;

    localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        t_val x;
        t_val y;
        t_val z;
    } t_vec3;

    typedef struct packed {
        t_op   op;
        t_word amount;
    } t_sb_fr;

    typedef struct packed {
        t_op   op;
        t_word amount;
        t_vec3 f;
    } t_sb_v1;

    typedef struct packed {
        t_op         op;
        t_word       amount;
        t_vec3       f;
        logic [31:0] a1;
        t_val        m;
    } t_sb_v2;

    typedef struct packed {
        t_op         op;
        t_vec3       f;
        logic [31:0] a1;
    } t_sb_r1;

    typedef struct packed {
        t_op   op;
        t_vec3 f;
        t_val  zz;
    } t_sb_r2;

    typedef struct packed {
        t_op   op;
        t_vec3 f;
    } t_sb_bk;

    // round to nearest on the q14 boundary, ties toward plus infinity
    function automatic t_val rnd14(input t_sum v);
        t_sum w;
        w = v + RND_HALF;
        w = w >>> 14;
        return w[VAL_W-1:0];
    endfunction

endpackage

### rtl/seed_frame_vector_rotator.sv
// throughput: one beat per cycle while the pipeline is not held by i_stall;
// every CORDIC iteration and multiply has its own stage
// the whole pipeline holds while a result waits under i_stall from the sink side
// reset clears every stage valid bit and loads the seed registers with
// cos 1.0 and sin 0 for both angles; configuration writes are taken every cycle
module seed_frame_vector_rotator #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic signed [15:0] i_vec_x,
    input  logic signed [15:0] i_vec_y,
    input  logic signed [15:0] i_vec_z,
    input  logic signed [15:0] i_lerp_amount,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_res_x,
    output logic signed [15:0] o_res_y,
    output logic signed [15:0] o_res_z,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import sfvr_pkg::*;

    // configuration
    t_word r_cos_alpha, r_sin_alpha, r_cos_beta, r_sin_beta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_alpha <= 16'sd16384;
            r_sin_alpha <= 16'sd0;
            r_cos_beta  <= 16'sd16384;
            r_sin_beta  <= 16'sd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COS_ALPHA: r_cos_alpha <= i_cfg_data;
                CFG_SIN_ALPHA: r_sin_alpha <= i_cfg_data;
                CFG_COS_BETA:  r_cos_beta  <= i_cfg_data;
                CFG_SIN_BETA:  r_sin_beta  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    t_coef w_ca, w_sa, w_cb, w_sb, w_nsa, w_nsb;
    assign w_ca  = t_coef'(r_cos_alpha);
    assign w_sa  = t_coef'(r_sin_alpha);
    assign w_cb  = t_coef'(r_cos_beta);
    assign w_sb  = t_coef'(r_sin_beta);
    assign w_nsa = -w_sa;
    assign w_nsb = -w_sb;

    // pipeline advance
    logic r_out_valid;
    logic w_adv;
    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !w_adv;

    // front rotation, first pair
    t_op    w_in_op;
    t_val   w_fa_a, w_fa_b, w_fa_keep;
    t_coef  w_fa_c, w_fa_s;
    t_sb_fr w_fa_sb;
    t_val   w_ix, w_iy, w_iz;

    assign w_in_op = t_op'(i_req_type);
    assign w_ix    = t_val'(i_vec_x);
    assign w_iy    = t_val'(i_vec_y);
    assign w_iz    = t_val'(i_vec_z);
    assign w_fa_sb = '{op: w_in_op, amount: i_lerp_amount};

    always_comb begin
        w_fa_a    = w_ix;
        w_fa_b    = w_iy;
        w_fa_keep = w_iz;
        w_fa_c    = w_ca;
        w_fa_s    = w_sa;
        case (w_in_op) inside
            OP_TO_SEED: begin
                w_fa_b    = w_iz;
                w_fa_keep = w_iy;
                w_fa_c    = w_cb;
                w_fa_s    = w_sb;
            end
            OP_FROM_SWAP: begin
                w_fa_a    = w_iz;
                w_fa_keep = w_ix;
            end
            OP_FROM_SEED, OP_LERP: ;
            default: ;
        endcase
    end

    logic   w_fa_v;
    t_val   w_fa_p, w_fa_q, w_fa_k;
    logic [$bits(t_sb_fr)-1:0] w_fa_sbo;
    t_sb_fr w_fa_o;

    sfvr_pair #(.SB_W($bits(t_sb_fr))) u_front_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_valid),
        .i_a     (w_fa_a),
        .i_b     (w_fa_b),
        .i_keep  (w_fa_keep),
        .i_c     (w_fa_c),
        .i_s     (w_fa_s),
        .i_sb    (w_fa_sb),
        .o_valid (w_fa_v),
        .o_p     (w_fa_p),
        .o_q     (w_fa_q),
        .o_keep  (w_fa_k),
        .o_sb    (w_fa_sbo)
    );
    assign w_fa_o = w_fa_sbo;

    // front rotation, second pair
    t_coef w_fb_c, w_fb_s;
    assign w_fb_c = (w_fa_o.op == OP_TO_SEED) ? w_ca  : w_cb;
    assign w_fb_s = (w_fa_o.op == OP_TO_SEED) ? w_nsa : w_nsb;

    logic   w_fb_v;
    t_val   w_fb_p, w_fb_q, w_fb_k;
    logic [$bits(t_sb_fr)-1:0] w_fb_sbo;
    t_sb_fr w_fb_o;

    sfvr_pair #(.SB_W($bits(t_sb_fr))) u_front_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_fa_v),
        .i_a     (w_fa_p),
        .i_b     (w_fa_k),
        .i_keep  (w_fa_q),
        .i_c     (w_fb_c),
        .i_s     (w_fb_s),
        .i_sb    (w_fa_sbo),
        .o_valid (w_fb_v),
        .o_p     (w_fb_p),
        .o_q     (w_fb_q),
        .o_keep  (w_fb_k),
        .o_sb    (w_fb_sbo)
    );
    assign w_fb_o = w_fb_sbo;

    // put the components back in x, y, z order
    t_vec3 w_f;
    always_comb begin
        w_f = '{x: w_fb_p, y: w_fb_k, z: w_fb_q};
        case (w_fb_o.op) inside
            OP_TO_SEED:   w_f = '{x: w_fb_p, y: w_fb_q, z: w_fb_k};
            OP_FROM_SWAP: w_f = '{x: w_fb_q, y: w_fb_k, z: w_fb_p};
            OP_FROM_SEED, OP_LERP: ;
            default: ;
        endcase
    end

    // azimuth of the unrotated vector
    t_sb_v1 w_v1_sb;
    assign w_v1_sb = '{op: w_fb_o.op, amount: w_fb_o.amount, f: w_f};

    logic        w_v1_v;
    t_val        w_v1_x, w_v1_y;
    logic [31:0] w_v1_ang;
    logic [$bits(t_sb_v1)-1:0] w_v1_sbo;
    t_sb_v1      w_v1_o;

    sfvr_cordic #(
        .STEPS     (CORDIC_STEPS),
        .VECTORING (1'b1),
        .SB_W      ($bits(t_sb_v1))
    ) u_vec_azim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_fb_v),
        .i_x     (w_f.y),
        .i_y     (w_f.x),
        .i_ang   (32'd0),
        .i_sb    (w_v1_sb),
        .o_valid (w_v1_v),
        .o_x     (w_v1_x),
        .o_y     (w_v1_y),
        .o_ang   (w_v1_ang),
        .o_sb    (w_v1_sbo)
    );
    assign w_v1_o = w_v1_sbo;

    // tilt angle against the seed axis
    t_sb_v2 w_v2_sb;
    assign w_v2_sb = '{op: w_v1_o.op, amount: w_v1_o.amount, f: w_v1_o.f,
                       a1: w_v1_ang, m: w_v1_x};

    logic        w_v2_v;
    t_val        w_v2_x, w_v2_y;
    logic [31:0] w_v2_ang;
    logic [$bits(t_sb_v2)-1:0] w_v2_sbo;
    t_sb_v2      w_v2_o;

    sfvr_cordic #(
        .STEPS     (CORDIC_STEPS),
        .VECTORING (1'b1),
        .SB_W      ($bits(t_sb_v2))
    ) u_vec_tilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_v1_v),
        .i_x     (w_v1_o.f.z),
        .i_y     (w_v1_x),
        .i_ang   (32'd0),
        .i_sb    (w_v2_sb),
        .o_valid (w_v2_v),
        .o_x     (w_v2_x),
        .o_y     (w_v2_y),
        .o_ang   (w_v2_ang),
        .o_sb    (w_v2_sbo)
    );
    assign w_v2_o = w_v2_sbo;

    // scale the tilt by the lerp amount
    t_ang w_b;
    always_comb begin
        w_b = t_ang'(signed'(w_v2_ang));
        // a tilt just past a half turn comes back negative
        if (w_b < -ANG_QUARTER) begin
            w_b = w_b + ANG_TURN;
        end
    end

    logic signed [49:0] r_prod;
    logic               r_mv;
    t_sb_v2             r_msb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (w_adv) begin
            r_mv <= w_v2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod <= w_b * w_v2_o.amount;
            r_msb  <= w_v2_o;
        end
    end

    // turn (m, z) in the y-z plane
    t_sb_r1 w_r1_sb;
    assign w_r1_sb = '{op: r_msb.op, f: r_msb.f, a1: r_msb.a1};

    logic        w_r1_v;
    t_val        w_r1_x, w_r1_y;
    logic [31:0] w_r1_ang;
    logic [$bits(t_sb_r1)-1:0] w_r1_sbo;
    t_sb_r1      w_r1_o;

    sfvr_cordic #(
        .STEPS     (CORDIC_STEPS),
        .VECTORING (1'b0),
        .SB_W      ($bits(t_sb_r1))
    ) u_rot_tilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_mv),
        .i_x     (r_msb.m),
        .i_y     (r_msb.f.z),
        .i_ang   (r_prod[45:14]),
        .i_sb    (w_r1_sb),
        .o_valid (w_r1_v),
        .o_x     (w_r1_x),
        .o_y     (w_r1_y),
        .o_ang   (w_r1_ang),
        .o_sb    (w_r1_sbo)
    );
    assign w_r1_o = w_r1_sbo;

    // undo the azimuth about z
    t_sb_r2      w_r2_sb;
    logic [31:0] w_neg_a1;
    assign w_r2_sb  = '{op: w_r1_o.op, f: w_r1_o.f, zz: w_r1_y};
    assign w_neg_a1 = 32'd0 - w_r1_o.a1;

    logic        w_r2_v;
    t_val        w_r2_x, w_r2_y;
    logic [31:0] w_r2_ang;
    logic [$bits(t_sb_r2)-1:0] w_r2_sbo;
    t_sb_r2      w_r2_o;

    sfvr_cordic #(
        .STEPS     (CORDIC_STEPS),
        .VECTORING (1'b0),
        .SB_W      ($bits(t_sb_r2))
    ) u_rot_azim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_r1_v),
        .i_x     ('0),
        .i_y     (w_r1_x),
        .i_ang   (w_neg_a1),
        .i_sb    (w_r2_sb),
        .o_valid (w_r2_v),
        .o_x     (w_r2_x),
        .o_y     (w_r2_y),
        .o_ang   (w_r2_ang),
        .o_sb    (w_r2_sbo)
    );
    assign w_r2_o = w_r2_sbo;

    // back into the seed frame
    t_sb_bk w_ba_sb;
    assign w_ba_sb = '{op: w_r2_o.op, f: w_r2_o.f};

    logic   w_ba_v;
    t_val   w_ba_p, w_ba_q, w_ba_k;
    logic [$bits(t_sb_bk)-1:0] w_ba_sbo;

    sfvr_pair #(.SB_W($bits(t_sb_bk))) u_back_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_r2_v),
        .i_a     (w_r2_x),
        .i_b     (w_r2_o.zz),
        .i_keep  (w_r2_y),
        .i_c     (w_cb),
        .i_s     (w_sb),
        .i_sb    (w_ba_sb),
        .o_valid (w_ba_v),
        .o_p     (w_ba_p),
        .o_q     (w_ba_q),
        .o_keep  (w_ba_k),
        .o_sb    (w_ba_sbo)
    );

    logic   w_bb_v;
    t_val   w_bb_p, w_bb_q, w_bb_k;
    logic [$bits(t_sb_bk)-1:0] w_bb_sbo;
    t_sb_bk w_bb_o;

    sfvr_pair #(.SB_W($bits(t_sb_bk))) u_back_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_ba_v),
        .i_a     (w_ba_p),
        .i_b     (w_ba_k),
        .i_keep  (w_ba_q),
        .i_c     (w_ca),
        .i_s     (w_nsa),
        .i_sb    (w_ba_sbo),
        .o_valid (w_bb_v),
        .o_p     (w_bb_p),
        .o_q     (w_bb_q),
        .o_keep  (w_bb_k),
        .o_sb    (w_bb_sbo)
    );
    assign w_bb_o = w_bb_sbo;

    // result select and clipping
    function automatic logic [16:0] sat_comp(input t_val v);
        logic [16:0] r;
        if (v > t_val'(32767)) begin
            r = {1'b1, 16'h7FFF};
        end else if (v < t_val'(-32768)) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, v[15:0]};
        end
        return r;
    endfunction

    t_vec3       w_res;
    logic [16:0] w_sx, w_sy, w_sz;

    assign w_res = (w_bb_o.op == OP_LERP) ? '{x: w_bb_p, y: w_bb_q, z: w_bb_k} : w_bb_o.f;
    assign w_sx  = sat_comp(w_res.x);
    assign w_sy  = sat_comp(w_res.y);
    assign w_sz  = sat_comp(w_res.z);

    logic [15:0] r_res_x, r_res_y, r_res_z;
    logic        r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_bb_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res_x <= w_sx[15:0];
            r_res_y <= w_sy[15:0];
            r_res_z <= w_sz[15:0];
            r_sat   <= w_sx[16] | w_sy[16] | w_sz[16];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_res_x     = r_res_x;
    assign o_res_y     = r_res_y;
    assign o_res_z     = r_res_z;
    assign o_saturated = r_sat;

endmodule

### rtl/sfvr_pair.sv
module sfvr_pair #(
    parameter int SB_W = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  sfvr_pkg::t_val  i_a,
    input  sfvr_pkg::t_val  i_b,
    input  sfvr_pkg::t_val  i_keep,
    input  sfvr_pkg::t_coef i_c,
    input  sfvr_pkg::t_coef i_s,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_valid,
    output sfvr_pkg::t_val  o_p,
    output sfvr_pkg::t_val  o_q,
    output sfvr_pkg::t_val  o_keep,
    output logic [SB_W-1:0] o_sb
);
    import sfvr_pkg::*;

    // p = c*a + s*b, q = c*b - s*a
    t_prod           r_m_ca, r_m_sb, r_m_cb, r_m_sa;
    t_val            r_m_keep;
    logic [SB_W-1:0] r_m_sb_data;
    logic            r_m_valid;

    t_val            r_p, r_q, r_keep;
    logic [SB_W-1:0] r_sb;
    logic            r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= i_valid;
            r_valid   <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_ca      <= i_c * i_a;
            r_m_sb      <= i_s * i_b;
            r_m_cb      <= i_c * i_b;
            r_m_sa      <= i_s * i_a;
            r_m_keep    <= i_keep;
            r_m_sb_data <= i_sb;
            r_p         <= rnd14(t_sum'(r_m_ca) + t_sum'(r_m_sb));
            r_q         <= rnd14(t_sum'(r_m_cb) - t_sum'(r_m_sa));
            r_keep      <= r_m_keep;
            r_sb        <= r_m_sb_data;
        end
    end

    assign o_valid = r_valid;
    assign o_p     = r_p;
    assign o_q     = r_q;
    assign o_keep  = r_keep;
    assign o_sb    = r_sb;

endmodule

### rtl/sfvr_cordic.sv
module sfvr_cordic #(
    parameter int STEPS     = 16,
    parameter bit VECTORING = 1'b0,
    parameter int SB_W      = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  sfvr_pkg::t_val  i_x,
    input  sfvr_pkg::t_val  i_y,
    input  logic [31:0]     i_ang,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_valid,
    output sfvr_pkg::t_val  o_x,
    output sfvr_pkg::t_val  o_y,
    output logic [31:0]     o_ang,
    output logic [SB_W-1:0] o_sb
);
    import sfvr_pkg::*;

    t_val            r_x  [0:STEPS];
    t_val            r_y  [0:STEPS];
    t_ang            r_z  [0:STEPS];
    logic            r_v  [0:STEPS];
    logic [SB_W-1:0] r_sb [0:STEPS];

    t_gprod          r_gx, r_gy;
    logic [31:0]     r_gz;
    logic            r_gv;
    logic [SB_W-1:0] r_gsb;

    t_val            r_ox, r_oy;
    logic [31:0]     r_oz;
    logic            r_ov;
    logic [SB_W-1:0] r_osb;

    t_val n_x0, n_y0;
    t_ang n_z0;

    // quadrant fold ahead of the micro-rotations
    always_comb begin
        t_ang w_ang;
        w_ang = t_ang'(signed'(i_ang));
        n_x0  = i_x;
        n_y0  = i_y;
        n_z0  = '0;
        if (VECTORING) begin
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    n_x0 = i_y;
                    n_y0 = -i_x;
                    n_z0 = ANG_QUARTER;
                end else begin
                    n_x0 = -i_y;
                    n_y0 = i_x;
                    n_z0 = -ANG_QUARTER;
                end
            end
        end else begin
            n_z0 = w_ang;
            if (w_ang > ANG_QUARTER) begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = w_ang - ANG_QUARTER;
            end else if (w_ang < -ANG_QUARTER) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = w_ang + ANG_QUARTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= n_x0;
            r_y[0]  <= n_y0;
            r_z[0]  <= n_z0;
            r_sb[0] <= i_sb;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam t_ang ATAN_I = t_ang'({2'b00, ATAN_TAB[i]});
        logic w_pos;

        // vectoring drives y toward zero, rotation drives the angle toward zero
        assign w_pos = VECTORING ? r_y[i][VAL_W-1] : !r_z[i][33];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_pos) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN_I;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN_I;
                end
                r_sb[i+1] <= r_sb[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_gv <= r_v[STEPS];
            r_ov <= r_gv;
        end
    end

    // gain removal
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gx  <= r_x[STEPS] * INV_GAIN;
            r_gy  <= r_y[STEPS] * INV_GAIN;
            r_gz  <= r_z[STEPS][31:0];
            r_gsb <= r_sb[STEPS];
            r_ox  <= rnd14(t_sum'(r_gx));
            r_oy  <= rnd14(t_sum'(r_gy));
            r_oz  <= r_gz;
            r_osb <= r_gsb;
        end
    end

    assign o_valid = r_ov;
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_ang   = r_oz;
    assign o_sb    = r_osb;

endmodule
